// File: hdl/qc2d_pkg.sv
// Shared types, codes and constants of the quantized 2D convolution engine.
// No dependencies; the interfaces, controller, datapath and top level import this package.
package qc2d_pkg;

	localparam int OP_W       = 2;
	localparam int COORD_W    = 6;
	localparam int CH_W       = 3;
	localparam int VALUE_W    = 16;
	localparam int SUM_W      = 32;
	localparam int DIM_W      = 7;
	localparam int FDIM_W     = 3;
	localparam int STRIDE_W   = 3;
	localparam int CHCNT_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int COUNT_W    = 8;
	localparam int PAD_W      = 10;
	localparam int POS_W      = 12;
	localparam int RECIP_W    = 17;
	localparam int RECIP_SH   = 16;

	localparam int DEF_MAX_IMAGE_DIM  = 64;
	localparam int DEF_MAX_FILTER_DIM = 7;
	localparam int DEF_MAX_CHANNELS   = 8;
	localparam int DEF_FRACTION_BITS  = 7;

	localparam logic [STRIDE_W-1:0] STRIDE_LIM = 3'd7;

	typedef enum logic [OP_W-1:0] {
		OP_PIXEL   = 2'd0,
		OP_WEIGHT  = 2'd1,
		OP_COMPUTE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_HEIGHT  = 3'd0,
		REG_IMAGE_WIDTH   = 3'd1,
		REG_FILTER_HEIGHT = 3'd2,
		REG_FILTER_WIDTH  = 3'd3,
		REG_ROW_STRIDE    = 3'd4,
		REG_COL_STRIDE    = 3'd5,
		REG_SAME_PADDING  = 3'd6,
		REG_OUT_CHANNELS  = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SIZE,
		S_PAD,
		S_BASE,
		S_TAP,
		S_DRAIN1,
		S_DRAIN2,
		S_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic wr_pixel;
		logic wr_weight;
		logic tap_init;
		logic issue;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic oor;
		logic tap_last;
	} sts_t;

	// ceil(2^16 / s): exact floor division for numerators below 256
	function automatic logic [RECIP_W-1:0] stride_recip(input logic [STRIDE_W-1:0] s);
		logic [RECIP_W-1:0] r;
		case (s)
			3'd2:    r = 17'd32768;
			3'd3:    r = 17'd21846;
			3'd4:    r = 17'd16384;
			3'd5:    r = 17'd13108;
			3'd6:    r = 17'd10923;
			3'd7:    r = 17'd9363;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/qc2d_ifs.sv
// Request and response channel interfaces of the convolution engine.
// Depends on qc2d_pkg for field widths.
interface qc2d_req_if import qc2d_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic [COORD_W-1:0]        row;
	logic [COORD_W-1:0]        col;
	logic [CH_W-1:0]           channel;
	logic signed [VALUE_W-1:0] value;

	modport source(output valid, operation, row, col, channel, value, input ready);
	modport sink(input valid, operation, row, col, channel, value, output ready);
endinterface

interface qc2d_rsp_if import qc2d_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] sum;
	logic                    out_of_range;

	modport source(output valid, sum, out_of_range, input ready);
	modport sink(input valid, sum, out_of_range, output ready);
endinterface

// File: hdl/qc2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qc2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/qc2d_ctrl.sv
// Sequencer of the convolution engine: accepts items, steps setup, tap walk
// and drain, and owns the response valid. Depends on qc2d_pkg.
module qc2d_ctrl import qc2d_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] in_op,
	output logic            in_ready,
	input  logic            out_ready,
	output logic            out_valid,
	output cmd_t            cmd,
	input  sts_t            sts
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept   = (state_q == S_IDLE) && in_valid;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (in_op == OP_COMPUTE)) begin
					state_nxt = S_SIZE;
				end
			end
			S_SIZE:   state_nxt = S_PAD;
			S_PAD:    state_nxt = S_BASE;
			S_BASE:   state_nxt = sts.oor ? S_DONE : S_TAP;
			S_TAP: begin
				if (sts.tap_last) begin
					state_nxt = S_DRAIN1;
				end
			end
			S_DRAIN1: state_nxt = S_DRAIN2;
			S_DRAIN2: state_nxt = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		in_ready      = (state_q == S_IDLE);
		cmd.capture   = accept && (in_op == OP_COMPUTE);
		cmd.wr_pixel  = accept && (in_op == OP_PIXEL);
		cmd.wr_weight = accept && (in_op == OP_WEIGHT);
		cmd.tap_init  = (state_q == S_BASE);
		cmd.issue     = (state_q == S_TAP);
		cmd.load_out  = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: hdl/qc2d_dpath.sv
// Datapath of the convolution engine: config registers, output geometry,
// image and weight stores, tap walk and multiply-accumulate.
// Depends on qc2d_pkg and qc2d_ram.
module qc2d_dpath import qc2d_pkg::*; #(
	parameter int MAX_IMAGE_DIM  = DEF_MAX_IMAGE_DIM,
	parameter int MAX_FILTER_DIM = DEF_MAX_FILTER_DIM,
	parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS,
	parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic [COORD_W-1:0]        row,
	input  logic [COORD_W-1:0]        col,
	input  logic [CH_W-1:0]           channel,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output logic signed [SUM_W-1:0]   sum,
	output logic                      out_of_range
);

	localparam int IMG_DEPTH = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
	localparam int WGT_DEPTH = MAX_FILTER_DIM * MAX_FILTER_DIM * MAX_CHANNELS;
	localparam int IA_W = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int WA_W = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
	localparam logic [DIM_W-1:0]   IMG_LIM = DIM_W'((MAX_IMAGE_DIM > 127) ? 127 : MAX_IMAGE_DIM);
	localparam logic [FDIM_W-1:0]  FLT_LIM = FDIM_W'((MAX_FILTER_DIM > 7) ? 7 : MAX_FILTER_DIM);
	localparam logic [CHCNT_W-1:0] CH_LIM  = CHCNT_W'((MAX_CHANNELS > 15) ? 15 : MAX_CHANNELS);

	function automatic logic [COUNT_W-1:0] axis_count(
		input logic [DIM_W-1:0]    in_dim,
		input logic [FDIM_W-1:0]   f_dim,
		input logic [STRIDE_W-1:0] s,
		input logic                same
	);
		logic [COUNT_W-1:0] num;
		logic [24:0]        prod;
		logic [COUNT_W-1:0] q;
		logic               fits;
		fits = in_dim >= DIM_W'(f_dim);
		if (same) begin
			num = COUNT_W'(in_dim) + COUNT_W'(s) - COUNT_W'(1);
		end else begin
			num = fits ? COUNT_W'(in_dim - DIM_W'(f_dim)) : '0;
		end
		prod = 25'(num) * 25'(stride_recip(s));
		q    = prod[RECIP_SH +: COUNT_W];
		if (same) begin
			return q;
		end
		return fits ? q + COUNT_W'(1) : '0;
	endfunction

	function automatic logic [PAD_W-1:0] lead_pad(
		input logic [COUNT_W-1:0]  n,
		input logic [DIM_W-1:0]    in_dim,
		input logic [FDIM_W-1:0]   f_dim,
		input logic [STRIDE_W-1:0] s
	);
		logic [10:0] t;
		logic [10:0] d;
		t = 11'(n - COUNT_W'(1)) * 11'(s) + 11'(f_dim);
		d = t - 11'(in_dim);
		if ((n != '0) && (t > 11'(in_dim))) begin
			return PAD_W'(d >> 1);
		end
		return '0;
	endfunction

	logic [DIM_W-1:0]    ih_q, iw_q;
	logic [FDIM_W-1:0]   fh_q, fw_q;
	logic [STRIDE_W-1:0] rs_q, cs_q;
	logic                same_q;
	logic [CHCNT_W-1:0]  oc_q;

	logic [DIM_W-1:0]    ih, iw;
	logic [FDIM_W-1:0]   fh, fw;
	logic [STRIDE_W-1:0] rs, cs;
	logic [CHCNT_W-1:0]  oc;

	logic [COORD_W-1:0]  row_q, col_q;
	logic [CH_W-1:0]     ch_q;
	logic [COUNT_W-1:0]  oh_q, ow_q;
	logic [PAD_W-1:0]    pt_q, pl_q;
	logic                oor_q;
	logic [POS_W-1:0]    rb_q, cb_q;
	logic [FDIM_W-1:0]   k_q, l_q;
	logic                k_end, l_end;

	logic [POS_W-1:0]    r_pos, c_pos;
	logic                tap_ok;
	logic [IA_W-1:0]     img_raddr, img_waddr;
	logic [WA_W-1:0]     wgt_raddr, wgt_waddr;
	logic                pix_in, wgt_in;
	logic [VALUE_W-1:0]  img_rdata, wgt_rdata;

	logic                    ok_s1, ok_s2;
	logic signed [SUM_W-1:0] prod_s2;
	logic signed [SUM_W-1:0] acc_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    oor_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ih_q   <= DIM_W'(64);
			iw_q   <= DIM_W'(64);
			fh_q   <= FDIM_W'(3);
			fw_q   <= FDIM_W'(3);
			rs_q   <= STRIDE_W'(1);
			cs_q   <= STRIDE_W'(1);
			same_q <= 1'b1;
			oc_q   <= CHCNT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_HEIGHT:  ih_q   <= cfg_data;
				REG_IMAGE_WIDTH:   iw_q   <= cfg_data;
				REG_FILTER_HEIGHT: fh_q   <= cfg_data[FDIM_W-1:0];
				REG_FILTER_WIDTH:  fw_q   <= cfg_data[FDIM_W-1:0];
				REG_ROW_STRIDE:    rs_q   <= cfg_data[STRIDE_W-1:0];
				REG_COL_STRIDE:    cs_q   <= cfg_data[STRIDE_W-1:0];
				REG_SAME_PADDING:  same_q <= cfg_data[0];
				REG_OUT_CHANNELS:  oc_q   <= cfg_data[CHCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ih = (ih_q == '0) ? DIM_W'(1) : ((ih_q > IMG_LIM) ? IMG_LIM : ih_q);
		iw = (iw_q == '0) ? DIM_W'(1) : ((iw_q > IMG_LIM) ? IMG_LIM : iw_q);
		fh = (fh_q == '0) ? FDIM_W'(1) : ((fh_q > FLT_LIM) ? FLT_LIM : fh_q);
		fw = (fw_q == '0) ? FDIM_W'(1) : ((fw_q > FLT_LIM) ? FLT_LIM : fw_q);
		rs = (rs_q == '0) ? STRIDE_W'(1) : ((rs_q > STRIDE_LIM) ? STRIDE_LIM : rs_q);
		cs = (cs_q == '0) ? STRIDE_W'(1) : ((cs_q > STRIDE_LIM) ? STRIDE_LIM : cs_q);
		oc = (oc_q == '0) ? CHCNT_W'(1) : ((oc_q > CH_LIM) ? CH_LIM : oc_q);
	end

	// geometry: sizes, then pads and range check, then base positions
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q <= row;
			col_q <= col;
			ch_q  <= channel;
		end
		oh_q  <= axis_count(ih, fh, rs, same_q);
		ow_q  <= axis_count(iw, fw, cs, same_q);
		pt_q  <= lead_pad(oh_q, ih, fh, rs);
		pl_q  <= lead_pad(ow_q, iw, fw, cs);
		oor_q <= (COUNT_W'(row_q) >= oh_q) || (COUNT_W'(col_q) >= ow_q) ||
			(CHCNT_W'(ch_q) >= oc);
		rb_q  <= POS_W'(row_q) * POS_W'(rs) - POS_W'(pt_q);
		cb_q  <= POS_W'(col_q) * POS_W'(cs) - POS_W'(pl_q);
	end

	assign k_end        = (k_q == fh - FDIM_W'(1));
	assign l_end        = (l_q == fw - FDIM_W'(1));
	assign sts.tap_last = k_end && l_end;
	assign sts.oor      = oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			l_q   <= '0;
			ok_s1 <= 1'b0;
			ok_s2 <= 1'b0;
		end else begin
			if (cmd.tap_init) begin
				k_q <= '0;
				l_q <= '0;
			end else if (cmd.issue) begin
				if (l_end) begin
					l_q <= '0;
					k_q <= k_q + FDIM_W'(1);
				end else begin
					l_q <= l_q + FDIM_W'(1);
				end
			end
			ok_s1 <= cmd.issue && tap_ok;
			ok_s2 <= ok_s1;
		end
	end

	always_comb begin
		r_pos     = rb_q + POS_W'(k_q);
		c_pos     = cb_q + POS_W'(l_q);
		tap_ok    = !r_pos[POS_W-1] && (r_pos < POS_W'(ih)) &&
			!c_pos[POS_W-1] && (c_pos < POS_W'(iw));
		img_raddr = IA_W'(32'(r_pos[POS_W-2:0]) * 32'(MAX_IMAGE_DIM) +
			32'(c_pos[POS_W-2:0]));
		wgt_raddr = WA_W'((32'(k_q) * 32'(MAX_FILTER_DIM) + 32'(l_q)) *
			32'(MAX_CHANNELS) + 32'(ch_q));
		img_waddr = IA_W'(32'(row) * 32'(MAX_IMAGE_DIM) + 32'(col));
		wgt_waddr = WA_W'((32'(row) * 32'(MAX_FILTER_DIM) + 32'(col)) *
			32'(MAX_CHANNELS) + 32'(channel));
		pix_in    = (32'(row) < 32'(MAX_IMAGE_DIM)) && (32'(col) < 32'(MAX_IMAGE_DIM));
		wgt_in    = (32'(row) < 32'(MAX_FILTER_DIM)) && (32'(col) < 32'(MAX_FILTER_DIM)) &&
			(32'(channel) < 32'(MAX_CHANNELS));
	end

	qc2d_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(IMG_DEPTH)
	) u_image_store (
		.clk  (clk),
		.we   (cmd.wr_pixel && pix_in),
		.waddr(img_waddr),
		.wdata(value),
		.raddr(img_raddr),
		.rdata(img_rdata)
	);

	qc2d_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(WGT_DEPTH)
	) u_weight_store (
		.clk  (clk),
		.we   (cmd.wr_weight && wgt_in),
		.waddr(wgt_waddr),
		.wdata(value),
		.raddr(wgt_raddr),
		.rdata(wgt_rdata)
	);

	always_ff @(posedge clk) begin
		prod_s2 <= SUM_W'($signed(img_rdata) * $signed(wgt_rdata));
		if (cmd.tap_init) begin
			acc_q <= '0;
		end else if (ok_s2) begin
			acc_q <= acc_q + (prod_s2 >>> FRACTION_BITS);
		end
		if (cmd.load_out) begin
			sum_q     <= oor_q ? '0 : acc_q;
			oor_out_q <= oor_q;
		end
	end

	assign sum          = sum_q;
	assign out_of_range = oor_out_q;

endmodule

// File: hdl/quantized_conv2d_engine.sv
// Top level of the quantized 2D convolution engine.
// Depends on qc2d_pkg, qc2d_ifs, qc2d_ctrl and qc2d_dpath.
//
// Usage:
//   req carries items: load pixel, load weight, or compute one output value.
//   rsp carries one result (sum, out_of_range) for each compute item only.
//   cfg_we/cfg_index/cfg_data write the eight geometry registers while idle.
// Throughput:
//   Pixel and weight loads may arrive back to back while the engine is idle.
//   A compute walks the filter taps one per cycle through a single
//   multiply-accumulate unit; an out-of-range request skips the walk.
//   req.ready is low during that walk.
// Reset:
//   Registers return to 64x64 image, 3x3 filter, stride 1, SAME, one channel.
//   The image and weight stores are not cleared; write before reading.
// Stall:
//   A result waits in the output register while rsp.ready is low; loads are
//   still accepted, and the next compute holds its result until it drains.
module quantized_conv2d_engine import qc2d_pkg::*; #(
	parameter int MAX_IMAGE_DIM  = DEF_MAX_IMAGE_DIM,
	parameter int MAX_FILTER_DIM = DEF_MAX_FILTER_DIM,
	parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS,
	parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	qc2d_req_if.sink              req,
	qc2d_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	qc2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.operation),
		.in_ready (req.ready),
		.out_ready(rsp.ready),
		.out_valid(rsp.valid),
		.cmd      (cmd),
		.sts      (sts)
	);

	qc2d_dpath #(
		.MAX_IMAGE_DIM (MAX_IMAGE_DIM),
		.MAX_FILTER_DIM(MAX_FILTER_DIM),
		.MAX_CHANNELS  (MAX_CHANNELS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.row         (req.row),
		.col         (req.col),
		.channel     (req.channel),
		.value       (req.value),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sum         (rsp.sum),
		.out_of_range(rsp.out_of_range)
	);

endmodule
